[rtl/qre_pkg.sv]
// ----------------------------------------------------------------------------
// qre_pkg
// Shared types, pipeline constants and Q16.16 helper functions for the
// quaternion rotation extraction unit.
// ----------------------------------------------------------------------------
package qre_pkg;

  typedef logic signed [31:0] word_t;
  typedef logic signed [47:0] prod_t;

  typedef struct packed {
    word_t x;
    word_t y;
    word_t z;
    word_t w;
  } quat_t;

  typedef struct packed {
    word_t g0;
    word_t g1;
    word_t g2;
    word_t det;
    word_t n0;
    word_t n1;
    word_t n2;
  } hess_t;

  typedef enum logic [1:0] {
    STEP_NEWTON   = 2'd0,
    STEP_SINGULAR = 2'd1,
    STEP_DESCENT  = 2'd2
  } step_kind_e;

  localparam word_t Q_ONE = 32'sd65536;

  localparam int HESS_LAT = 9;
  localparam int DIV_NW   = 49;
  localparam int DIV_DW   = 34;
  localparam int DIV_QW   = 33;
  localparam int DIV_LAT  = DIV_QW + 2;
  localparam int CAY_STG  = HESS_LAT + 2 * DIV_LAT + 4;
  localparam int KIND_DLY = DIV_LAT + 4;
  localparam int PIPE_LAT = HESS_LAT + 2 * DIV_LAT + 7;

  // Q16.16 product, floored.
  function automatic prod_t qm(input word_t a, input word_t b);
    logic signed [63:0] p;
    p = 64'(a) * 64'(b);
    return p[63:16];
  endfunction

  function automatic logic signed [63:0] x64(input prod_t v);
    return 64'(v);
  endfunction

  function automatic word_t sat(input logic signed [63:0] v);
    if (v > 64'sd2147483647) begin
      return 32'sh7FFFFFFF;
    end else if (v < -64'sd2147483648) begin
      return 32'sh80000000;
    end
    return v[31:0];
  endfunction

endpackage

[rtl/qre_ram.sv]
// ----------------------------------------------------------------------------
// qre_ram
// Generic single-write, single-read synchronous RAM with registered read.
// ----------------------------------------------------------------------------
module qre_ram #(
  parameter int WIDTH = 128,
  parameter int DEPTH = 1024
) (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                       wdata_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                       rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/qre_div.sv]
// ----------------------------------------------------------------------------
// qre_div
// Fully pipelined signed restoring divider, one quotient bit per stage,
// truncating toward zero and saturating the quotient to 32 bits.
// ----------------------------------------------------------------------------
module qre_div #(
  parameter int NW = 49,
  parameter int DW = 34,
  parameter int QW = 33
) (
  input  logic                 clk_i,
  input  logic signed [NW-1:0] num_i,
  input  logic signed [DW-1:0] den_i,
  output logic signed [31:0]   quo_o
);

  localparam int RW = DW + QW;

  logic [RW-1:0] rem_q [QW+1];
  logic [DW-1:0] dm_q  [QW+1];
  logic [QW-1:0] qt_q  [QW+1];
  logic          neg_q [QW+1];
  logic          ovf_q [QW+1];

  logic [RW-1:0] rem_d [QW+1];
  logic [QW-1:0] qt_d  [QW+1];
  logic [NW-1:0] nmag;
  logic [DW-1:0] dmag;
  logic [63:0]   qz;
  logic signed [31:0] quo_d, quo_q;

  assign nmag = num_i[NW-1] ? (~num_i + 1'b1) : num_i;
  assign dmag = den_i[DW-1] ? (~den_i + 1'b1) : den_i;

  // Each stage tries the shifted divisor against the partial remainder.
  always_comb begin
    logic [RW-1:0] ds;
    rem_d[0] = '0;
    qt_d[0]  = '0;
    for (int k = 1; k <= QW; k++) begin
      ds = RW'(dm_q[k-1]) << (QW - k);
      rem_d[k] = rem_q[k-1];
      qt_d[k]  = qt_q[k-1];
      if (rem_q[k-1] >= ds) begin
        rem_d[k] = rem_q[k-1] - ds;
        qt_d[k][QW-k] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q[0] <= RW'(nmag);
    dm_q[0]  <= dmag;
    qt_q[0]  <= '0;
    neg_q[0] <= num_i[NW-1] ^ den_i[DW-1];
    ovf_q[0] <= RW'(nmag) >= {dmag, {QW{1'b0}}};
    for (int k = 1; k <= QW; k++) begin
      rem_q[k] <= rem_d[k];
      dm_q[k]  <= dm_q[k-1];
      qt_q[k]  <= qt_d[k];
      neg_q[k] <= neg_q[k-1];
      ovf_q[k] <= ovf_q[k-1];
    end
    quo_q <= quo_d;
  end

  assign qz = 64'(qt_q[QW]);

  always_comb begin
    if (ovf_q[QW]) begin
      quo_d = neg_q[QW] ? 32'sh80000000 : 32'sh7FFFFFFF;
    end else if (!neg_q[QW]) begin
      quo_d = (qz > 64'h7FFF_FFFF) ? 32'sh7FFFFFFF : signed'(qz[31:0]);
    end else begin
      quo_d = (qz > 64'h8000_0000) ? 32'sh80000000 : signed'(-qz[31:0]);
    end
  end

  assign quo_o = quo_q;

endmodule

[rtl/qre_hess.sv]
// ----------------------------------------------------------------------------
// qre_hess
// Pipelined front end: rotation matrix, B = R^T F, gradient, Hessian,
// adjugate, determinant and adj(H) g.
// ----------------------------------------------------------------------------
module qre_hess (
  input  logic            clk_i,
  input  qre_pkg::quat_t  q_i,
  input  qre_pkg::word_t  f_i [3][3],
  output qre_pkg::hess_t  hess_o
);
  import qre_pkg::*;

  prod_t qp_q [9];
  word_t f1_q [3][3];
  word_t f2_q [3][3];
  word_t r_q  [3][3];
  prod_t bp_q [3][3][3];
  word_t b_q  [3][3];
  word_t g5_q [3], g6_q [3], g7_q [3], g8_q [3];
  word_t hd_q [3];
  word_t ho_q [3];
  prod_t hp_q [12];
  word_t hc6_q [3], hc7_q [3];
  word_t in_q [5];
  word_t adj_q [3][3];
  prod_t dp_q [5];
  prod_t np_q [3][3];
  hess_t hess_q;

  logic signed [63:0] s01, s02, s12;

  assign s01 = 64'(b_q[1][0]) + 64'(b_q[0][1]);
  assign s02 = 64'(b_q[2][0]) + 64'(b_q[0][2]);
  assign s12 = 64'(b_q[2][1]) + 64'(b_q[1][2]);

  always_ff @(posedge clk_i) begin
    // Quaternion products: xx yy zz xy xz yz xw yw zw.
    qp_q[0] <= qm(q_i.x, q_i.x);
    qp_q[1] <= qm(q_i.y, q_i.y);
    qp_q[2] <= qm(q_i.z, q_i.z);
    qp_q[3] <= qm(q_i.x, q_i.y);
    qp_q[4] <= qm(q_i.x, q_i.z);
    qp_q[5] <= qm(q_i.y, q_i.z);
    qp_q[6] <= qm(q_i.x, q_i.w);
    qp_q[7] <= qm(q_i.y, q_i.w);
    qp_q[8] <= qm(q_i.z, q_i.w);
    f1_q <= f_i;

    r_q[0][0] <= sat(64'sd65536 - 2 * (x64(qp_q[1]) + x64(qp_q[2])));
    r_q[0][1] <= sat(2 * (x64(qp_q[3]) - x64(qp_q[8])));
    r_q[0][2] <= sat(2 * (x64(qp_q[4]) + x64(qp_q[7])));
    r_q[1][0] <= sat(2 * (x64(qp_q[3]) + x64(qp_q[8])));
    r_q[1][1] <= sat(64'sd65536 - 2 * (x64(qp_q[0]) + x64(qp_q[2])));
    r_q[1][2] <= sat(2 * (x64(qp_q[5]) - x64(qp_q[6])));
    r_q[2][0] <= sat(2 * (x64(qp_q[4]) - x64(qp_q[7])));
    r_q[2][1] <= sat(2 * (x64(qp_q[5]) + x64(qp_q[6])));
    r_q[2][2] <= sat(64'sd65536 - 2 * (x64(qp_q[0]) + x64(qp_q[1])));
    f2_q <= f1_q;

    for (int j = 0; j < 3; j++) begin
      for (int i = 0; i < 3; i++) begin
        for (int m = 0; m < 3; m++) begin
          bp_q[j][i][m] <= qm(r_q[m][i], f2_q[j][m]);
        end
        b_q[j][i] <= sat(x64(bp_q[j][i][0]) + x64(bp_q[j][i][1]) + x64(bp_q[j][i][2]));
      end
    end

    g5_q[0] <= sat(64'(b_q[2][1]) - 64'(b_q[1][2]));
    g5_q[1] <= sat(64'(b_q[0][2]) - 64'(b_q[2][0]));
    g5_q[2] <= sat(64'(b_q[1][0]) - 64'(b_q[0][1]));
    hd_q[0] <= sat(64'(b_q[1][1]) + 64'(b_q[2][2]));
    hd_q[1] <= sat(64'(b_q[0][0]) + 64'(b_q[2][2]));
    hd_q[2] <= sat(64'(b_q[0][0]) + 64'(b_q[1][1]));
    ho_q[0] <= sat((s01 * -64'sd32768) >>> 16);
    ho_q[1] <= sat((s02 * -64'sd32768) >>> 16);
    ho_q[2] <= sat((s12 * -64'sd32768) >>> 16);

    // Hessian products; hd = h00 h11 h22, ho = h01 h02 h12.
    hp_q[0]  <= qm(hd_q[0], hd_q[1]);
    hp_q[1]  <= qm(hd_q[0], ho_q[2]);
    hp_q[2]  <= qm(hd_q[0], hd_q[2]);
    hp_q[3]  <= qm(ho_q[0], ho_q[0]);
    hp_q[4]  <= qm(ho_q[0], ho_q[1]);
    hp_q[5]  <= qm(ho_q[0], ho_q[2]);
    hp_q[6]  <= qm(ho_q[0], hd_q[2]);
    hp_q[7]  <= qm(ho_q[1], ho_q[1]);
    hp_q[8]  <= qm(ho_q[1], hd_q[1]);
    hp_q[9]  <= qm(ho_q[1], ho_q[2]);
    hp_q[10] <= qm(hd_q[1], hd_q[2]);
    hp_q[11] <= qm(ho_q[2], ho_q[2]);
    hc6_q[0] <= hd_q[1];
    hc6_q[1] <= ho_q[2];
    hc6_q[2] <= hd_q[2];
    g6_q <= g5_q;

    in_q[0] <= sat(x64(hp_q[7]));
    in_q[1] <= sat(x64(hp_q[4]));
    in_q[2] <= sat(x64(hp_q[1]));
    in_q[3] <= sat(x64(hp_q[3]));
    in_q[4] <= sat(x64(hp_q[0]));
    adj_q[0][0] <= sat(x64(hp_q[10]) - x64(hp_q[11]));
    adj_q[0][1] <= sat(x64(hp_q[9]) - x64(hp_q[6]));
    adj_q[1][0] <= sat(x64(hp_q[9]) - x64(hp_q[6]));
    adj_q[0][2] <= sat(x64(hp_q[5]) - x64(hp_q[8]));
    adj_q[2][0] <= sat(x64(hp_q[5]) - x64(hp_q[8]));
    adj_q[1][1] <= sat(x64(hp_q[2]) - x64(hp_q[7]));
    adj_q[1][2] <= sat(x64(hp_q[4]) - x64(hp_q[1]));
    adj_q[2][1] <= sat(x64(hp_q[4]) - x64(hp_q[1]));
    adj_q[2][2] <= sat(x64(hp_q[0]) - x64(hp_q[3]));
    hc7_q <= hc6_q;
    g7_q  <= g6_q;

    dp_q[0] <= qm(in_q[0], hc7_q[0]);
    dp_q[1] <= qm(in_q[1], hc7_q[1]);
    dp_q[2] <= qm(in_q[2], hc7_q[1]);
    dp_q[3] <= qm(in_q[3], hc7_q[2]);
    dp_q[4] <= qm(in_q[4], hc7_q[2]);
    for (int i = 0; i < 3; i++) begin
      for (int k = 0; k < 3; k++) begin
        np_q[i][k] <= qm(adj_q[i][k], g7_q[k]);
      end
    end
    g8_q <= g7_q;

    hess_q.det <= sat(-x64(dp_q[0]) + 2 * x64(dp_q[1]) - x64(dp_q[2])
                      - x64(dp_q[3]) + x64(dp_q[4]));
    hess_q.n0  <= sat(x64(np_q[0][0]) + x64(np_q[0][1]) + x64(np_q[0][2]));
    hess_q.n1  <= sat(x64(np_q[1][0]) + x64(np_q[1][1]) + x64(np_q[1][2]));
    hess_q.n2  <= sat(x64(np_q[2][0]) + x64(np_q[2][1]) + x64(np_q[2][2]));
    hess_q.g0  <= g8_q[0];
    hess_q.g1  <= g8_q[1];
    hess_q.g2  <= g8_q[2];
  end

  assign hess_o = hess_q;

endmodule

[rtl/quaternion_rotation_extraction_unit.sv]
// ----------------------------------------------------------------------------
// quaternion_rotation_extraction_unit
// One Newton step of analytic polar decomposition per tetrahedron, with a
// warm-start quaternion per tetrahedron held in on-chip RAM.
// ----------------------------------------------------------------------------
// Usage. An item (tet_index_i and the nine Q16.16 entries of F) is
// transferred at a rising edge where start_i is high and busy_o is low.
// At the end of the pipeline done_o is high for one cycle with the
// updated quaternion and step_kind_o; the receiver cannot stall, so the
// result must be taken in that cycle.
// Throughput is one item per cycle while busy_o is low. The depth is set
// by the two pipelined divider banks (Newton solve and Cayley map, 35 stages
// each) and the multiply/add stages around them. All state sits in one
// 128-bit wide RAM with one write and one registered read port; the read is
// issued at the transfer and the write-back happens in the final stage.
// busy_o also rises while an item for the same tetrahedron is anywhere in
// the pipeline, since that entry has not yet been written back; items for
// other tetrahedra pass freely.
// After reset a clearing pass writes the identity quaternion to every entry,
// one entry a cycle, and busy_o stays high until the pass is complete.
// ----------------------------------------------------------------------------
module quaternion_rotation_extraction_unit #(
  parameter int NUM_TETS = 1024
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  output logic               busy_o,
  input  logic [9:0]         tet_index_i,
  input  logic signed [31:0] f_c0_x_i,
  input  logic signed [31:0] f_c0_y_i,
  input  logic signed [31:0] f_c0_z_i,
  input  logic signed [31:0] f_c1_x_i,
  input  logic signed [31:0] f_c1_y_i,
  input  logic signed [31:0] f_c1_z_i,
  input  logic signed [31:0] f_c2_x_i,
  input  logic signed [31:0] f_c2_y_i,
  input  logic signed [31:0] f_c2_z_i,
  output logic               done_o,
  output logic signed [31:0] rot_x_o,
  output logic signed [31:0] rot_y_o,
  output logic signed [31:0] rot_z_o,
  output logic signed [31:0] rot_w_o,
  output logic [1:0]         step_kind_o
);
  import qre_pkg::*;

  localparam int IW = (NUM_TETS > 1) ? $clog2(NUM_TETS) : 1;

  // Clearing pass state.
  logic          clr_act_q;
  logic [IW-1:0] clr_cnt_q;

  // Item tracking along the whole pipeline.
  logic          vl_q [PIPE_LAT];
  logic [IW-1:0] ix_q [PIPE_LAT];

  logic [IW-1:0] idx_in;
  logic          hazard;
  logic          accept;

  word_t f0_q [3][3];
  quat_t ram_rd;
  quat_t ram_wd;
  logic  ram_we;
  logic [IW-1:0] ram_wa;
  hess_t hess;

  word_t gd_q [DIV_LAT][3];
  logic  dz_q [DIV_LAT];
  quat_t qd_q [CAY_STG];
  word_t nq [3];

  word_t om_sel [3];
  word_t om10_q [3], alt10_q [3];
  prod_t dp10_q [3];
  logic  dz10_q;
  word_t om11_q [3];
  step_kind_e kind11_q;
  step_kind_e kd_q [KIND_DLY];
  prod_t sq12_q [3];
  word_t om12_q [3];
  word_t l2_q;
  word_t om13_q [3];
  word_t cw;
  word_t cv [3];
  prod_t rp_q [16];
  quat_t res_q;
  quat_t qc;
  logic signed [63:0] dot;

  // Fold the index into the table: conditional subtraction of NUM_TETS
  // scaled by falling powers of two.
  always_comb begin
    logic [31:0] wr;
    wr = 32'(tet_index_i);
    for (int k = 9; k >= 0; k--) begin
      if ((32'(NUM_TETS) << k) <= 32'd1023 && wr >= (32'(NUM_TETS) << k)) begin
        wr = wr - (32'(NUM_TETS) << k);
      end
    end
    idx_in = wr[IW-1:0];
  end

  // Read-modify-write interlock: the entry is stale while any earlier item
  // for it is still in flight, including the one being written back now.
  always_comb begin
    hazard = 1'b0;
    for (int s = 0; s < PIPE_LAT; s++) begin
      if (vl_q[s] && ix_q[s] == idx_in) begin
        hazard = 1'b1;
      end
    end
  end

  assign busy_o = clr_act_q | hazard;
  assign accept = start_i & ~busy_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_act_q <= 1'b1;
      clr_cnt_q <= '0;
      for (int s = 0; s < PIPE_LAT; s++) begin
        vl_q[s] <= 1'b0;
      end
    end else begin
      if (clr_act_q) begin
        clr_cnt_q <= clr_cnt_q + 1'b1;
        if (clr_cnt_q == IW'(NUM_TETS - 1)) begin
          clr_act_q <= 1'b0;
        end
      end
      vl_q[0] <= accept;
      for (int s = 1; s < PIPE_LAT; s++) begin
        vl_q[s] <= vl_q[s-1];
      end
    end
  end

  // Payload pipeline registers.
  always_ff @(posedge clk_i) begin
    ix_q[0] <= idx_in;
    for (int s = 1; s < PIPE_LAT; s++) begin
      ix_q[s] <= ix_q[s-1];
    end
    f0_q[0][0] <= f_c0_x_i;
    f0_q[0][1] <= f_c0_y_i;
    f0_q[0][2] <= f_c0_z_i;
    f0_q[1][0] <= f_c1_x_i;
    f0_q[1][1] <= f_c1_y_i;
    f0_q[1][2] <= f_c1_z_i;
    f0_q[2][0] <= f_c2_x_i;
    f0_q[2][1] <= f_c2_y_i;
    f0_q[2][2] <= f_c2_z_i;
  end

  // Write-back port is shared with the clearing pass; no item is in flight
  // while the pass runs.
  assign ram_we = clr_act_q | vl_q[PIPE_LAT-1];
  assign ram_wa = clr_act_q ? clr_cnt_q : ix_q[PIPE_LAT-1];
  assign ram_wd = clr_act_q ? quat_t'{x: '0, y: '0, z: '0, w: Q_ONE} : res_q;

  qre_ram #(
    .WIDTH ($bits(quat_t)),
    .DEPTH (NUM_TETS)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_wa),
    .wdata_i (ram_wd),
    .raddr_i (idx_in),
    .rdata_o (ram_rd)
  );

  qre_hess u_hess (
    .clk_i  (clk_i),
    .q_i    (ram_rd),
    .f_i    (f0_q),
    .hess_o (hess)
  );

  // Newton solve: omega = -0.25 * n / det.
  qre_div #(.NW(DIV_NW), .DW(DIV_DW), .QW(DIV_QW)) u_ndiv0 (
    .clk_i (clk_i),
    .num_i (DIV_NW'(64'(hess.n0) * -64'sd16384)),
    .den_i (DIV_DW'(hess.det)),
    .quo_o (nq[0])
  );
  qre_div #(.NW(DIV_NW), .DW(DIV_DW), .QW(DIV_QW)) u_ndiv1 (
    .clk_i (clk_i),
    .num_i (DIV_NW'(64'(hess.n1) * -64'sd16384)),
    .den_i (DIV_DW'(hess.det)),
    .quo_o (nq[1])
  );
  qre_div #(.NW(DIV_NW), .DW(DIV_DW), .QW(DIV_QW)) u_ndiv2 (
    .clk_i (clk_i),
    .num_i (DIV_NW'(64'(hess.n2) * -64'sd16384)),
    .den_i (DIV_DW'(hess.det)),
    .quo_o (nq[2])
  );

  // Side data that travels alongside the dividers.
  always_ff @(posedge clk_i) begin
    gd_q[0][0] <= hess.g0;
    gd_q[0][1] <= hess.g1;
    gd_q[0][2] <= hess.g2;
    dz_q[0]    <= (hess.det == '0);
    for (int k = 1; k < DIV_LAT; k++) begin
      gd_q[k] <= gd_q[k-1];
      dz_q[k] <= dz_q[k-1];
    end
    qd_q[0] <= ram_rd;
    for (int k = 1; k < CAY_STG; k++) begin
      qd_q[k] <= qd_q[k-1];
    end
  end

  // A singular Hessian falls back to the negative gradient.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      om_sel[i] = dz_q[DIV_LAT-1] ? sat(-64'(gd_q[DIV_LAT-1][i])) : nq[i];
    end
  end

  assign dot = x64(dp10_q[0]) + x64(dp10_q[1]) + x64(dp10_q[2]);

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      om10_q[i]  <= om_sel[i];
      alt10_q[i] <= sat((64'(gd_q[DIV_LAT-1][i]) * -64'sd8192) >>> 16);
      dp10_q[i]  <= qm(om_sel[i], gd_q[DIV_LAT-1][i]);
    end
    dz10_q <= dz_q[DIV_LAT-1];

    // An uphill step is replaced by a short descent step.
    if (dot > 64'sd0) begin
      om11_q   <= alt10_q;
      kind11_q <= STEP_DESCENT;
    end else begin
      om11_q   <= om10_q;
      kind11_q <= dz10_q ? STEP_SINGULAR : STEP_NEWTON;
    end

    kd_q[0] <= kind11_q;
    for (int k = 1; k < KIND_DLY; k++) begin
      kd_q[k] <= kd_q[k-1];
    end

    for (int i = 0; i < 3; i++) begin
      sq12_q[i] <= qm(om11_q[i], om11_q[i]);
    end
    om12_q <= om11_q;

    l2_q   <= sat(x64(sq12_q[0]) + x64(sq12_q[1]) + x64(sq12_q[2]));
    om13_q <= om12_q;
  end

  // Cayley map: w = (1 - l2) / (1 + l2), v = 2 omega / (1 + l2).
  qre_div #(.NW(DIV_NW), .DW(DIV_DW), .QW(DIV_QW)) u_cdivw (
    .clk_i (clk_i),
    .num_i (DIV_NW'((64'sd65536 - 64'(l2_q)) <<< 16)),
    .den_i (DIV_DW'(64'sd65536 + 64'(l2_q))),
    .quo_o (cw)
  );
  qre_div #(.NW(DIV_NW), .DW(DIV_DW), .QW(DIV_QW)) u_cdivx (
    .clk_i (clk_i),
    .num_i (DIV_NW'(64'(om13_q[0]) <<< 17)),
    .den_i (DIV_DW'(64'sd65536 + 64'(l2_q))),
    .quo_o (cv[0])
  );
  qre_div #(.NW(DIV_NW), .DW(DIV_DW), .QW(DIV_QW)) u_cdivy (
    .clk_i (clk_i),
    .num_i (DIV_NW'(64'(om13_q[1]) <<< 17)),
    .den_i (DIV_DW'(64'sd65536 + 64'(l2_q))),
    .quo_o (cv[1])
  );
  qre_div #(.NW(DIV_NW), .DW(DIV_DW), .QW(DIV_QW)) u_cdivz (
    .clk_i (clk_i),
    .num_i (DIV_NW'(64'(om13_q[2]) <<< 17)),
    .den_i (DIV_DW'(64'sd65536 + 64'(l2_q))),
    .quo_o (cv[2])
  );

  assign qc = qd_q[CAY_STG-1];

  // Right-multiply the stored quaternion by the Cayley quaternion.
  always_ff @(posedge clk_i) begin
    rp_q[0]  <= qm(qc.w, cw);
    rp_q[1]  <= qm(qc.x, cv[0]);
    rp_q[2]  <= qm(qc.y, cv[1]);
    rp_q[3]  <= qm(qc.z, cv[2]);
    rp_q[4]  <= qm(qc.w, cv[0]);
    rp_q[5]  <= qm(qc.x, cw);
    rp_q[6]  <= qm(qc.y, cv[2]);
    rp_q[7]  <= qm(qc.z, cv[1]);
    rp_q[8]  <= qm(qc.w, cv[1]);
    rp_q[9]  <= qm(qc.x, cv[2]);
    rp_q[10] <= qm(qc.y, cw);
    rp_q[11] <= qm(qc.z, cv[0]);
    rp_q[12] <= qm(qc.w, cv[2]);
    rp_q[13] <= qm(qc.x, cv[1]);
    rp_q[14] <= qm(qc.y, cv[0]);
    rp_q[15] <= qm(qc.z, cw);

    res_q.w <= sat(x64(rp_q[0]) - x64(rp_q[1]) - x64(rp_q[2]) - x64(rp_q[3]));
    res_q.x <= sat(x64(rp_q[4]) + x64(rp_q[5]) + x64(rp_q[6]) - x64(rp_q[7]));
    res_q.y <= sat(x64(rp_q[8]) - x64(rp_q[9]) + x64(rp_q[10]) + x64(rp_q[11]));
    res_q.z <= sat(x64(rp_q[12]) + x64(rp_q[13]) - x64(rp_q[14]) + x64(rp_q[15]));
  end

  assign done_o      = vl_q[PIPE_LAT-1];
  assign rot_x_o     = res_q.x;
  assign rot_y_o     = res_q.y;
  assign rot_z_o     = res_q.z;
  assign rot_w_o     = res_q.w;
  assign step_kind_o = kd_q[KIND_DLY-1];

endmodule

[rtl/qre_checker.sv]
// ----------------------------------------------------------------------------
// qre_port_checker
// Port-level checks of latency, result bookkeeping, the interlock, the clearing pass and the step kind.
// ----------------------------------------------------------------------------
module qre_port_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       start_i,
  input logic       busy_o,
  input logic [9:0] tet_index_i,
  input logic       done_o,
  input logic [1:0] step_kind_o
);
  import qre_pkg::*;

  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o |-> ##PIPE_LAT done_o)
    else $error("transfer not answered after the pipeline latency");

  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start_i && !busy_o, PIPE_LAT))
    else $error("result without a matching transfer");

  a_same_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o ##1 start_i && tet_index_i == $past(tet_index_i) |-> busy_o)
    else $error("back-to-back transfer to one entry was not held off");

  a_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$past(rst_ni) |-> busy_o)
    else $error("not busy during the clearing pass");

  a_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> step_kind_o == STEP_NEWTON || step_kind_o == STEP_SINGULAR
               || step_kind_o == STEP_DESCENT)
    else $error("result with an unknown step kind");

endmodule

bind quaternion_rotation_extraction_unit qre_port_checker u_qre_checker (.*);

[sim/qre_checker.sv]
// ----------------------------------------------------------------------------
// qre_checker
// Watches the command and result channels of the rotation extraction unit.
// It predicts every result from its own copy of the quaternion store and
// compares the results field by field, counting mismatches and unexpected results.
// ----------------------------------------------------------------------------
module qre_checker #(
  parameter int NUM_TETS = 1024
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic               busy_i,
  input  logic [9:0]         tet_index_i,
  input  logic [8:0][31:0]   f_i,
  input  logic               done_i,
  input  logic signed [31:0] rot_x_i,
  input  logic signed [31:0] rot_y_i,
  input  logic signed [31:0] rot_z_i,
  input  logic signed [31:0] rot_w_i,
  input  logic [1:0]         step_kind_i,
  output int                 pending_o,
  output int                 errors_o
);
  import qre_pkg::*;

  typedef struct {
    word_t      x;
    word_t      y;
    word_t      z;
    word_t      w;
    step_kind_e kind;
  } rot_result_t;

  word_t       qx_mem [NUM_TETS];
  word_t       qy_mem [NUM_TETS];
  word_t       qz_mem [NUM_TETS];
  word_t       qw_mem [NUM_TETS];
  rot_result_t rot_queue [$];

  // Floored Q16.16 product at full width.
  function automatic longint fxm(input word_t a, input word_t b);
    longint p;
    p = longint'(a) * longint'(b);
    return p >>> 16;
  endfunction

  function automatic word_t clamp32(input longint v);
    if (v > 64'sd2147483647) begin
      return 32'sh7FFFFFFF;
    end else if (v < -64'sd2147483648) begin
      return 32'sh80000000;
    end
    return word_t'(v[31:0]);
  endfunction

  // One Newton step for one tetrahedron; updates the store and returns the result.
  task automatic newton_update(input int idx, input logic [8:0][31:0] fm,
                               output rot_result_t res);
    word_t  f [3][3];
    word_t  r [3][3];
    word_t  b [3][3];
    word_t  g [3];
    word_t  om [3];
    word_t  n [3];
    word_t  cv [3];
    word_t  qx, qy, qz, qw;
    word_t  h00, h11, h22, h01, h02, h12, det;
    word_t  a00, a01, a02, a11, a12, a22, l2, cw;
    longint dot, den;
    int     i, j;
    qx = qx_mem[idx];
    qy = qy_mem[idx];
    qz = qz_mem[idx];
    qw = qw_mem[idx];
    for (j = 0; j < 3; j++) begin
      for (i = 0; i < 3; i++) begin
        f[j][i] = word_t'(fm[3 * j + i]);
      end
    end
    res.kind = STEP_NEWTON;

    r[0][0] = clamp32(65536 - 2 * (fxm(qy, qy) + fxm(qz, qz)));
    r[0][1] = clamp32(2 * (fxm(qx, qy) - fxm(qz, qw)));
    r[0][2] = clamp32(2 * (fxm(qx, qz) + fxm(qy, qw)));
    r[1][0] = clamp32(2 * (fxm(qx, qy) + fxm(qz, qw)));
    r[1][1] = clamp32(65536 - 2 * (fxm(qx, qx) + fxm(qz, qz)));
    r[1][2] = clamp32(2 * (fxm(qy, qz) - fxm(qx, qw)));
    r[2][0] = clamp32(2 * (fxm(qx, qz) - fxm(qy, qw)));
    r[2][1] = clamp32(2 * (fxm(qy, qz) + fxm(qx, qw)));
    r[2][2] = clamp32(65536 - 2 * (fxm(qx, qx) + fxm(qy, qy)));

    // Column j of B is R transposed applied to column j of F.
    for (j = 0; j < 3; j++) begin
      for (i = 0; i < 3; i++) begin
        b[j][i] = clamp32(fxm(r[0][i], f[j][0]) + fxm(r[1][i], f[j][1])
                          + fxm(r[2][i], f[j][2]));
      end
    end

    g[0] = clamp32(longint'(b[2][1]) - b[1][2]);
    g[1] = clamp32(longint'(b[0][2]) - b[2][0]);
    g[2] = clamp32(longint'(b[1][0]) - b[0][1]);

    h00 = clamp32(longint'(b[1][1]) + b[2][2]);
    h11 = clamp32(longint'(b[0][0]) + b[2][2]);
    h22 = clamp32(longint'(b[0][0]) + b[1][1]);
    h01 = clamp32(((longint'(b[1][0]) + b[0][1]) * -32768) >>> 16);
    h02 = clamp32(((longint'(b[2][0]) + b[0][2]) * -32768) >>> 16);
    h12 = clamp32(((longint'(b[2][1]) + b[1][2]) * -32768) >>> 16);

    det = clamp32(-fxm(clamp32(fxm(h02, h02)), h11)
                  + 2 * fxm(clamp32(fxm(h01, h02)), h12)
                  - fxm(clamp32(fxm(h00, h12)), h12)
                  - fxm(clamp32(fxm(h01, h01)), h22)
                  + fxm(clamp32(fxm(h00, h11)), h22));

    a00 = clamp32(fxm(h11, h22) - fxm(h12, h12));
    a01 = clamp32(fxm(h02, h12) - fxm(h01, h22));
    a02 = clamp32(fxm(h01, h12) - fxm(h02, h11));
    a11 = clamp32(fxm(h00, h22) - fxm(h02, h02));
    a12 = clamp32(fxm(h01, h02) - fxm(h00, h12));
    a22 = clamp32(fxm(h00, h11) - fxm(h01, h01));

    if (det == 0) begin
      // Singular Hessian: plain negative gradient.
      for (i = 0; i < 3; i++) begin
        om[i] = clamp32(-longint'(g[i]));
      end
      res.kind = STEP_SINGULAR;
    end else begin
      n[0] = clamp32(fxm(a00, g[0]) + fxm(a01, g[1]) + fxm(a02, g[2]));
      n[1] = clamp32(fxm(a01, g[0]) + fxm(a11, g[1]) + fxm(a12, g[2]));
      n[2] = clamp32(fxm(a02, g[0]) + fxm(a12, g[1]) + fxm(a22, g[2]));
      for (i = 0; i < 3; i++) begin
        om[i] = clamp32((longint'(n[i]) * -16384) / longint'(det));
      end
    end

    // An uphill step is replaced by a short descent step whatever came before.
    dot = fxm(om[0], g[0]) + fxm(om[1], g[1]) + fxm(om[2], g[2]);
    if (dot > 0) begin
      for (i = 0; i < 3; i++) begin
        om[i] = clamp32(fxm(g[i], -32'sd8192));
      end
      res.kind = STEP_DESCENT;
    end

    l2  = clamp32(fxm(om[0], om[0]) + fxm(om[1], om[1]) + fxm(om[2], om[2]));
    den = 65536 + longint'(l2);
    cw  = clamp32(((65536 - longint'(l2)) * 65536) / den);
    for (i = 0; i < 3; i++) begin
      cv[i] = clamp32((longint'(om[i]) * 131072) / den);
    end

    res.w = clamp32(fxm(qw, cw) - fxm(qx, cv[0]) - fxm(qy, cv[1]) - fxm(qz, cv[2]));
    res.x = clamp32(fxm(qw, cv[0]) + fxm(qx, cw) + fxm(qy, cv[2]) - fxm(qz, cv[1]));
    res.y = clamp32(fxm(qw, cv[1]) - fxm(qx, cv[2]) + fxm(qy, cw) + fxm(qz, cv[0]));
    res.z = clamp32(fxm(qw, cv[2]) + fxm(qx, cv[1]) - fxm(qy, cv[0]) + fxm(qz, cw));

    qx_mem[idx] = res.x;
    qy_mem[idx] = res.y;
    qz_mem[idx] = res.z;
    qw_mem[idx] = res.w;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    rot_result_t nxt;
    rot_result_t exp_r;
    if (!rst_ni) begin
      for (int k = 0; k < NUM_TETS; k++) begin
        qx_mem[k] = '0;
        qy_mem[k] = '0;
        qz_mem[k] = '0;
        qw_mem[k] = Q_ONE;
      end
      rot_queue.delete();
      pending_o <= 0;
      errors_o  <= 0;
    end else begin
      if (start_i && !busy_i) begin
        newton_update(int'(tet_index_i) % NUM_TETS, f_i, nxt);
        rot_queue = {rot_queue, nxt};
      end
      if (done_i) begin
        if (rot_queue.size() == 0) begin
          $error("result with no transfer outstanding");
          errors_o <= errors_o + 1;
        end else begin
          exp_r = rot_queue.pop_front();
          if (rot_x_i !== exp_r.x || rot_y_i !== exp_r.y || rot_z_i !== exp_r.z ||
              rot_w_i !== exp_r.w || step_kind_i !== exp_r.kind) begin
            errors_o <= errors_o + 1;
          end
          if (rot_x_i !== exp_r.x) $error("rot_x: expected %0d, got %0d", exp_r.x, rot_x_i);
          if (rot_y_i !== exp_r.y) $error("rot_y: expected %0d, got %0d", exp_r.y, rot_y_i);
          if (rot_z_i !== exp_r.z) $error("rot_z: expected %0d, got %0d", exp_r.z, rot_z_i);
          if (rot_w_i !== exp_r.w) $error("rot_w: expected %0d, got %0d", exp_r.w, rot_w_i);
          if (step_kind_i !== exp_r.kind) begin
            $error("step_kind: expected %0d, got %0d", exp_r.kind, step_kind_i);
          end
        end
      end
      pending_o <= rot_queue.size();
    end
  end

endmodule

[sim/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// Drives tetrahedron updates into the rotation extraction unit: a directed
// set of deformation gradients first, then random ones over a few idling
// phases. A checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module testbench;
  import qre_pkg::*;

  localparam int N_RANDOM  = 1500;
  localparam int CYCLE_MAX = 1000000;
  localparam int DRAIN_CYC = PIPE_LAT + 20;

  logic               clk_i;
  logic               rst_ni;
  logic               start_i;
  logic               busy_o;
  logic [9:0]         tet_index_i;
  logic [8:0][31:0]   f_q;
  logic               done_o;
  logic signed [31:0] rot_x_o;
  logic signed [31:0] rot_y_o;
  logic signed [31:0] rot_z_o;
  logic signed [31:0] rot_w_o;
  logic [1:0]         step_kind_o;
  int                 pending;
  int                 mismatches;
  int                 cycles;
  int                 idle_pct;

  quaternion_rotation_extraction_unit i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .busy_o      (busy_o),
    .tet_index_i (tet_index_i),
    .f_c0_x_i    (f_q[0]),
    .f_c0_y_i    (f_q[1]),
    .f_c0_z_i    (f_q[2]),
    .f_c1_x_i    (f_q[3]),
    .f_c1_y_i    (f_q[4]),
    .f_c1_z_i    (f_q[5]),
    .f_c2_x_i    (f_q[6]),
    .f_c2_y_i    (f_q[7]),
    .f_c2_z_i    (f_q[8]),
    .done_o      (done_o),
    .rot_x_o     (rot_x_o),
    .rot_y_o     (rot_y_o),
    .rot_z_o     (rot_z_o),
    .rot_w_o     (rot_w_o),
    .step_kind_o (step_kind_o)
  );

  qre_checker i_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .busy_i      (busy_o),
    .tet_index_i (tet_index_i),
    .f_i         (f_q),
    .done_i      (done_o),
    .rot_x_i     (rot_x_o),
    .rot_y_i     (rot_y_o),
    .rot_z_i     (rot_z_o),
    .rot_w_i     (rot_w_o),
    .step_kind_i (step_kind_o),
    .pending_o   (pending),
    .errors_o    (mismatches)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Watchdog. The slowest honest run is the clearing pass plus every item
  // stalled behind its predecessor for the full pipeline depth, which is
  // well under a fifth of this limit.
  initial begin
    cycles = 0;
    forever begin
      @(posedge clk_i);
      cycles++;
      if (cycles >= CYCLE_MAX) begin
        $display("testbench: done, errors");
        $finish;
      end
    end
  end

  // Presents one item and holds it until the block takes it. On return we
  // sit in the time step of the transfer edge, so the caller makes the one
  // assignment to start_i for the next cycle.
  task automatic send_item(input logic [9:0] tet, input logic [8:0][31:0] fm);
    start_i     <= 1'b1;
    tet_index_i <= tet;
    f_q         <= fm;
    do @(posedge clk_i); while (busy_o);
  endtask

  // Random idle cycles before the next item, at the current phase's rate.
  task automatic idle_gap();
    while ($urandom_range(0, 99) < idle_pct) begin
      start_i <= 1'b0;
      @(posedge clk_i);
    end
  endtask

  // One matrix entry. Mode 0 stays close to the identity with moderate stretch
  // so the Newton solve does real work; modes 1 and 2 range wider; the last reaches the corners.
  function automatic logic [31:0] rand_entry(input int mode, input bit diag);
    logic [31:0] v;
    case (mode)
      0: v = 32'($signed(diag ? 65536 : 0) + $signed($urandom_range(0, 65536)) - 32768);
      1: v = 32'($signed($urandom_range(0, 524288)) - 262144);
      2: v = $urandom;
      default: begin
        case ($urandom_range(0, 5))
          0: v = 32'h8000_0000;
          1: v = 32'h7FFF_FFFF;
          2: v = 32'h0000_0000;
          3: v = 32'h0001_0000;
          4: v = 32'hFFFF_0000;
          default: v = 32'hFFFF_FFFF;
        endcase
      end
    endcase
    return v;
  endfunction

  initial begin
    logic [8:0][31:0] fm;
    logic [9:0]       tet;
    int               mode;
    int               sel;
    rst_ni      = 1'b0;
    start_i     = 1'b0;
    tet_index_i = '0;
    f_q         = '0;
    idle_pct    = 0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part. Identity from identity gives a zero gradient and a plain
    // Newton step; a zero matrix gives a singular Hessian; the corners
    // saturate every stage; a skewed matrix tends to push the solve uphill.
    fm = '{default: 32'h0};
    fm[0] = 32'h0001_0000; fm[4] = 32'h0001_0000; fm[8] = 32'h0001_0000;
    send_item(10'd0, fm);
    send_item(10'd1023, '0);
    send_item(10'd1, '{default: 32'h7FFF_FFFF});
    send_item(10'd2, '{default: 32'h8000_0000});
    send_item(10'd3, '{default: 32'hFFFF_FFFF});
    fm = '{default: 32'h0};
    fm[0] = 32'hFFFF_0000; fm[4] = 32'hFFFF_0000; fm[8] = 32'hFFFF_0000;
    send_item(10'd4, fm);
    fm = '{default: 32'h0};
    fm[1] = 32'h0001_0000; fm[3] = 32'hFFFF_0000; fm[8] = 32'h0001_0000;
    send_item(10'd5, fm);
    fm = '{default: 32'h0};
    fm[1] = 32'h0002_0000; fm[3] = 32'h0002_0000; fm[8] = 32'h0000_8000;
    send_item(10'd6, fm);
    fm = '{default: 32'h5555_5555};
    fm[2] = 32'hAAAA_AAAA; fm[6] = 32'h8000_0000;
    send_item(10'd512, fm);
    fm = '{default: 32'h0};
    fm[0] = 32'h7FFF_FFFF; fm[4] = 32'h8000_0000; fm[7] = 32'h7FFF_FFFF;
    send_item(10'd7, fm);
    // The same tetrahedron repeatedly, so the warm start moves away from identity.
    for (int k = 0; k < 6; k++) begin
      for (int e = 0; e < 9; e++) fm[e] = rand_entry(0, e % 4 == 0);
      send_item(10'd9, fm);
    end

    // Random part in four idling phases.
    for (int item = 0; item < N_RANDOM; item++) begin
      case (item * 4 / N_RANDOM)
        0: idle_pct = 0;
        1: idle_pct = 73;
        2: idle_pct = 0;
        default: idle_pct = 38;
      endcase
      // Halfway through, hold off until every outstanding result is back.
      if (item == N_RANDOM / 2) begin
        start_i <= 1'b0;
        do @(posedge clk_i); while (pending != 0);
      end else begin
        idle_gap();
      end
      sel = $urandom_range(0, 99);
      mode = (sel < 60) ? 0 : (sel < 75) ? 1 : (sel < 90) ? 2 : 3;
      // A small pool of tetrahedra carries long update chains; the rest
      // spread over the whole index range.
      tet = ($urandom_range(0, 99) < 70) ? 10'($urandom_range(0, 15)) : 10'($urandom);
      for (int e = 0; e < 9; e++) fm[e] = rand_entry(mode, e % 4 == 0);
      send_item(tet, fm);
    end
    start_i <= 1'b0;

    do @(posedge clk_i); while (pending != 0);
    repeat (DRAIN_CYC) @(posedge clk_i);
    if (mismatches == 0 && pending == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/qre_pkg.sv
rtl/qre_ram.sv
rtl/qre_div.sv
rtl/qre_hess.sv
rtl/quaternion_rotation_extraction_unit.sv
rtl/qre_checker.sv
sim/qre_checker.sv
sim/testbench.sv
